FILE: src/slbd_pkg.sv
// Shared constants, item types and table geometry for the SAX lower-bound distance block.
// Used by the channel interfaces, the front end, the back end and the top level.
// Has no dependencies of its own.
package slbd_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SYMBOL_BITS  = 8;
    localparam int SYMBOL_COUNT = 1 << SYMBOL_BITS;
    localparam int ENTRIES      = SYMBOL_COUNT + 1;
    localparam int TABLE_DEPTH  = MAX_SEGMENTS * ENTRIES;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);

    localparam int SEG_W   = 4;
    localparam int SLOT_W  = 9;
    localparam int SYM_W   = 8;
    localparam int VALUE_W = 32;
    localparam int SCALE_W = 32;
    localparam int DIST_W  = 64;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_FLUSH
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [ADDR_W-1:0]    addr;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } t_op;

endpackage

FILE: src/slbd_if.sv
// Channel interfaces of the SAX lower-bound distance block: items, results and the
// scale register write channel. Depends on slbd_pkg for field widths.
interface slbd_item_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [slbd_pkg::SEG_W-1:0]          segment;
    logic [slbd_pkg::SLOT_W-1:0]         breakpoint_slot;
    logic [slbd_pkg::SYM_W-1:0]          symbol;
    logic signed [slbd_pkg::VALUE_W-1:0] value;
    logic                                last;

    modport source (output valid, cmd, segment, breakpoint_slot, symbol, value, last,
                    input ready);
    modport sink   (input valid, cmd, segment, breakpoint_slot, symbol, value, last,
                    output ready);
endinterface

interface slbd_res_if;
    logic                         valid;
    logic                         ready;
    logic [slbd_pkg::DIST_W-1:0]  distance;
    logic                         saturated;

    modport source (output valid, distance, saturated, input ready);
    modport sink   (input valid, distance, saturated, output ready);
endinterface

interface slbd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [slbd_pkg::SCALE_W-1:0]  scale;

    modport source (output valid, scale, input ready);
    modport sink   (input valid, scale, output ready);
endinterface

FILE: src/slbd_front.sv
// Front end: accepts item beats, classifies them into table writes, queries and bare
// flushes, forms table addresses and holds them in a short queue. Depends on slbd_pkg.
module slbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slbd_item_if.sink     i_item,
    output slbd_pkg::t_op o_op,
    output logic          o_op_valid,
    input  logic          i_op_pop
);

    slbd_pkg::t_op                     r_queue [slbd_pkg::QUEUE_DEPTH];
    logic [slbd_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [slbd_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [slbd_pkg::QCNT_W-1:0]       r_count;
    logic [slbd_pkg::QPTR_W-1:0]       n_wr_ptr;
    logic [slbd_pkg::QPTR_W-1:0]       n_rd_ptr;
    logic [slbd_pkg::QCNT_W-1:0]       n_count;

    logic                              accept;
    logic                              seg_ok;
    logic                              slot_ok;
    logic [slbd_pkg::SYM_W-1:0]        sym_masked;
    logic                              push;
    slbd_pkg::t_op                     new_op;

    assign i_item.ready = (r_count != slbd_pkg::QCNT_W'(slbd_pkg::QUEUE_DEPTH));
    assign accept       = i_item.valid && i_item.ready;

    assign seg_ok     = int'(i_item.segment) < slbd_pkg::MAX_SEGMENTS;
    assign slot_ok    = int'(i_item.breakpoint_slot) < slbd_pkg::ENTRIES;
    assign sym_masked = i_item.symbol & slbd_pkg::SYM_W'(slbd_pkg::SYMBOL_COUNT - 1);

    // Out-of-range segments and slots never reach the back end; a query on a missing
    // segment still has to close the word when it carries the last mark.
    always_comb begin
        new_op.value = i_item.value;
        new_op.last  = i_item.last;
        new_op.kind  = slbd_pkg::OP_QUERY;
        new_op.addr  = slbd_pkg::ADDR_W'(int'(i_item.segment) * slbd_pkg::ENTRIES
                                         + int'(sym_masked));
        push         = 1'b0;
        if (i_item.cmd == slbd_pkg::CMD_WRITE) begin
            new_op.kind = slbd_pkg::OP_WRITE;
            new_op.addr = slbd_pkg::ADDR_W'(int'(i_item.segment) * slbd_pkg::ENTRIES
                                            + int'(i_item.breakpoint_slot));
            push        = accept && seg_ok && slot_ok;
        end else if (seg_ok) begin
            push = accept;
        end else begin
            new_op.kind = slbd_pkg::OP_FLUSH;
            push        = accept && i_item.last;
        end
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_op_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_op_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_op_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_op;
        end
    end

    assign o_op       = r_queue[r_rd_ptr];
    assign o_op_valid = (r_count != '0);

endmodule

FILE: src/slbd_back.sv
// Back end: breakpoint table memory, gap and square datapath, saturating sum, scaling
// and the result register, run by a one-hot sequencer. Depends on slbd_pkg and slbd_if.
module slbd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slbd_cfg_if.sink      i_cfg,
    input  slbd_pkg::t_op i_op,
    input  logic          i_op_valid,
    output logic          o_op_pop,
    slbd_res_if.source    o_result
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,
        S_GAP    = 7'b000_0010,
        S_SQ     = 7'b000_0100,
        S_ACC    = 7'b000_1000,
        S_MUL_LO = 7'b001_0000,
        S_MUL_HI = 7'b010_0000,
        S_EMIT   = 7'b100_0000
    } t_state;

    t_state                            r_state;
    t_state                            n_state;

    logic [slbd_pkg::VALUE_W-1:0]      r_table [slbd_pkg::TABLE_DEPTH];
    logic [slbd_pkg::VALUE_W-1:0]      r_rd_lo;
    logic [slbd_pkg::VALUE_W-1:0]      r_rd_hi;
    logic [slbd_pkg::ADDR_W-1:0]       addr_hi;
    logic                              mem_we;
    logic                              mem_re;

    logic [slbd_pkg::VALUE_W-1:0]      r_value;
    logic                              r_last;
    logic [slbd_pkg::VALUE_W-1:0]      r_gap;
    logic [slbd_pkg::VALUE_W-1:0]      n_gap;
    logic [slbd_pkg::DIST_W-1:0]       r_sq;
    logic [slbd_pkg::DIST_W-1:0]       r_sum;
    logic [slbd_pkg::DIST_W-1:0]       n_sum;
    logic                              r_ovf;
    logic                              n_ovf;
    logic [slbd_pkg::DIST_W-1:0]       r_p_lo;
    logic [slbd_pkg::DIST_W-1:0]       r_p_hi;
    logic [slbd_pkg::SCALE_W-1:0]      r_scale;

    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [slbd_pkg::DIST_W-1:0]       r_dist;
    logic                              r_sat;

    logic [slbd_pkg::DIST_W:0]         acc;
    logic                              hi_ovf;
    logic [slbd_pkg::DIST_W-1:0]       part_a;
    logic [slbd_pkg::DIST_W-1:0]       part_b;
    logic [slbd_pkg::DIST_W:0]         scaled;
    logic                              scaled_ovf;
    logic                              out_free;
    logic                              emit;

    assign i_cfg.ready = 1'b1;

    assign o_op_pop = (r_state == S_IDLE) && i_op_valid;
    assign mem_we   = o_op_pop && (i_op.kind == slbd_pkg::OP_WRITE);
    assign mem_re   = o_op_pop && (i_op.kind == slbd_pkg::OP_QUERY);
    assign addr_hi  = i_op.addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[i_op.addr] <= i_op.value;
        end
        if (mem_re) begin
            r_rd_lo <= r_table[i_op.addr];
            r_rd_hi <= r_table[addr_hi];
        end
    end

    // The floor test wins when the table is out of order.
    always_comb begin
        if ($signed(r_value) < $signed(r_rd_lo)) begin
            n_gap = r_rd_lo - r_value;
        end else if ($signed(r_rd_hi) < $signed(r_value)) begin
            n_gap = r_value - r_rd_hi;
        end else begin
            n_gap = '0;
        end
    end

    assign acc = {1'b0, r_sum} + {1'b0, r_sq};

    // The Q48.48 product is rebuilt from its two halves and cut back to Q32.32.
    assign hi_ovf     = |r_p_hi[slbd_pkg::DIST_W-1:48];
    assign part_a     = {r_p_hi[47:0], 16'b0};
    assign part_b     = {16'b0, r_p_lo[slbd_pkg::DIST_W-1:16]};
    assign scaled     = {1'b0, part_a} + {1'b0, part_b};
    assign scaled_ovf = hi_ovf || scaled[slbd_pkg::DIST_W];

    assign out_free = !r_out_valid || o_result.ready;
    assign emit     = (r_state == S_EMIT) && out_free;

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_ovf   = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (o_op_pop && (i_op.kind == slbd_pkg::OP_QUERY)) begin
                    n_state = S_GAP;
                end else if (o_op_pop && (i_op.kind == slbd_pkg::OP_FLUSH)) begin
                    n_state = S_MUL_LO;
                end
            end
            S_GAP:    n_state = S_SQ;
            S_SQ:     n_state = S_ACC;
            S_ACC: begin
                if (acc[slbd_pkg::DIST_W]) begin
                    n_sum = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_sum = acc[slbd_pkg::DIST_W-1:0];
                end
                n_state = r_last ? S_MUL_LO : S_IDLE;
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_sum   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_scale     <= slbd_pkg::SCALE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_scale <= i_cfg.scale;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_value <= i_op.value;
            r_last  <= i_op.last;
        end
        r_gap <= n_gap;
        r_sq  <= slbd_pkg::DIST_W'(r_gap) * slbd_pkg::DIST_W'(r_gap);
        if (r_state == S_MUL_LO) begin
            r_p_lo <= slbd_pkg::DIST_W'(r_sum[31:0]) * slbd_pkg::DIST_W'(r_scale);
        end
        if (r_state == S_MUL_HI) begin
            r_p_hi <= slbd_pkg::DIST_W'(r_sum[63:32]) * slbd_pkg::DIST_W'(r_scale);
        end
        if (emit) begin
            r_dist <= scaled_ovf ? '1 : scaled[slbd_pkg::DIST_W-1:0];
            r_sat  <= r_ovf || scaled_ovf;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.distance  = r_dist;
    assign o_result.saturated = r_sat;

endmodule

FILE: src/sax_lower_bound_distance.sv
// Top level of the SAX lower-bound distance block: joins the front end and the back end
// through the operation queue. Depends on slbd_pkg, slbd_if, slbd_front and slbd_back.
//
//   channel    direction  beat carries
//   i_item     in         cmd, segment, breakpoint_slot, symbol, value, last
//   i_cfg      in         scale (always ready)
//   o_result   out        distance, saturated
//
// A table write is done by the back end in its idle state; a query element passes through the
// gap, square and accumulate states, and the last element of a word then through the two
// scaling multiply states, which split the scaling into two 32 by 32 multiplies, and the result stage.
// The front queue holds four beats, so items are taken while the back end works.
// Reset is synchronous; the table is not cleared and needs no clearing pass.
// A result that is not taken holds the sequencer in its result stage; the queue then fills
// and drops i_item.ready.
module sax_lower_bound_distance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slbd_item_if.sink  i_item,
    slbd_cfg_if.sink   i_cfg,
    slbd_res_if.source o_result
);

    slbd_pkg::t_op op;
    logic          op_valid;
    logic          op_pop;

    slbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_pop   (op_pop)
    );

    slbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_pop   (op_pop),
        .o_result   (o_result)
    );

endmodule

FILE: src/slbd_checker.sv
// Port-level checks for the SAX lower-bound distance block, bound to the top level.
// Depends on slbd_pkg and on the ports of sax_lower_bound_distance.
module slbd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_item_ready,
    input logic                         i_cfg_ready,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [slbd_pkg::DIST_W-1:0]  i_res_distance,
    input logic                         i_res_saturated
);

    // A result beat that is not taken stays offered.
    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat withdrawn before it was taken");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_distance) && $stable(i_res_saturated))
        else $error("result payload changed while stalled");

    // Straight after reset the queue is empty and no result is pending.
    a_reset_clean: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_res_valid && i_item_ready)
        else $error("block not empty after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_cfg_ready)
        else $error("scale register write channel stalled");

endmodule

bind sax_lower_bound_distance slbd_checker u_slbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_item_ready    (i_item.ready),
    .i_cfg_ready     (i_cfg.ready),
    .i_res_valid     (o_result.valid),
    .i_res_ready     (o_result.ready),
    .i_res_distance  (o_result.distance),
    .i_res_saturated (o_result.saturated)
);
